@@ rtl/spi_pkg.sv @@
package spi_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int FIELD_W        = 16;
    localparam int PT_W           = 24;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_end_x;
        logic signed [FIELD_W-1:0] a_end_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_end_x;
        logic signed [FIELD_W-1:0] b_end_y;
    } spi_in_t;

    typedef struct packed {
        logic                   hit;
        logic                   parallel;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
    } spi_out_t;

endpackage

@@ rtl/spi_front.sv @@
module spi_front
    import spi_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF,
    localparam int DW = CB + 1,
    localparam int PW = 2 * DW,
    localparam int XW = PW + 1,
    localparam int NW = XW + DW + FB,
    localparam int W  = CB + FB + 2,
    localparam int SW = 4 + 4 * W
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  spi_in_t         in_data,
    output logic            valid,
    output logic [NW-1:0]   num_x,
    output logic [NW-1:0]   num_y,
    output logic [XW-1:0]   den,
    output logic [SW-1:0]   side
);

    function automatic logic in_box(
        input logic signed [CB-1:0] px,
        input logic signed [CB-1:0] py,
        input logic signed [CB-1:0] qx,
        input logic signed [CB-1:0] qy,
        input logic signed [CB-1:0] rx,
        input logic signed [CB-1:0] ry
    );
        logic okx;
        logic oky;
        okx = (px < rx) ? (qx >= px && qx <= rx) : (qx >= rx && qx <= px);
        oky = (py < ry) ? (qy >= py && qy <= ry) : (qy >= ry && qy <= py);
        return okx && oky;
    endfunction

    function automatic logic opposite(input logic signed [XW-1:0] u,
                                      input logic signed [XW-1:0] v);
        return (u > 0 && v < 0) || (u < 0 && v > 0);
    endfunction

    // coordinates: low CB bits of the field, sign-extended
    logic signed [CB-1:0] ax, ay, ex, ey, bx, by, fx, fy;
    assign ax = $signed(CB'($unsigned(in_data.a_start_x)));
    assign ay = $signed(CB'($unsigned(in_data.a_start_y)));
    assign ex = $signed(CB'($unsigned(in_data.a_end_x)));
    assign ey = $signed(CB'($unsigned(in_data.a_end_y)));
    assign bx = $signed(CB'($unsigned(in_data.b_start_x)));
    assign by = $signed(CB'($unsigned(in_data.b_start_y)));
    assign fx = $signed(CB'($unsigned(in_data.b_end_x)));
    assign fy = $signed(CB'($unsigned(in_data.b_end_y)));

    // stage 1: differences and box tests
    logic                 v1_reg;
    logic signed [DW-1:0] adx1_reg, ady1_reg, bdx1_reg, bdy1_reg;
    logic signed [DW-1:0] abx1_reg, aby1_reg, afx1_reg, afy1_reg, ebx1_reg, eby1_reg;
    logic [3:0]           box1_reg;
    logic signed [CB-1:0] ax1_reg, ay1_reg, ex1_reg, ey1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adx1_reg <= DW'(ex) - DW'(ax);
            ady1_reg <= DW'(ey) - DW'(ay);
            bdx1_reg <= DW'(fx) - DW'(bx);
            bdy1_reg <= DW'(fy) - DW'(by);
            abx1_reg <= DW'(bx) - DW'(ax);
            aby1_reg <= DW'(by) - DW'(ay);
            afx1_reg <= DW'(fx) - DW'(ax);
            afy1_reg <= DW'(fy) - DW'(ay);
            ebx1_reg <= DW'(ex) - DW'(bx);
            eby1_reg <= DW'(ey) - DW'(by);
            box1_reg <= {in_box(ax, ay, fx, fy, ex, ey),
                         in_box(ax, ay, bx, by, ex, ey),
                         in_box(bx, by, ex, ey, fx, fy),
                         in_box(bx, by, ax, ay, fx, fy)};
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            ex1_reg  <= ex;
            ey1_reg  <= ey;
        end
    end

    // stage 2: products; slots are d1, d2, d3, d4, den, num
    logic signed [PW-1:0] pa_next [6];
    logic signed [PW-1:0] pb_next [6];
    logic signed [PW-1:0] pa_reg  [6];
    logic signed [PW-1:0] pb_reg  [6];
    logic                 v2_reg;
    logic signed [DW-1:0] adx2_reg, ady2_reg;
    logic [3:0]           box2_reg;
    logic signed [CB-1:0] ax2_reg, ay2_reg, ex2_reg, ey2_reg;

    always_comb
    begin
        pa_next[0] = bdy1_reg * abx1_reg;
        pb_next[0] = bdx1_reg * aby1_reg;
        pa_next[1] = bdx1_reg * eby1_reg;
        pb_next[1] = bdy1_reg * ebx1_reg;
        pa_next[2] = adx1_reg * aby1_reg;
        pb_next[2] = ady1_reg * abx1_reg;
        pa_next[3] = adx1_reg * afy1_reg;
        pb_next[3] = ady1_reg * afx1_reg;
        pa_next[4] = adx1_reg * bdy1_reg;
        pb_next[4] = ady1_reg * bdx1_reg;
        pa_next[5] = abx1_reg * bdy1_reg;
        pb_next[5] = aby1_reg * bdx1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            adx2_reg <= adx1_reg;
            ady2_reg <= ady1_reg;
            box2_reg <= box1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
        end
    end

    // stage 3: cross products
    logic signed [XW-1:0] cr_reg [6];
    logic                 v3_reg;
    logic signed [DW-1:0] adx3_reg, ady3_reg;
    logic [3:0]           box3_reg;
    logic signed [CB-1:0] ax3_reg, ay3_reg, ex3_reg, ey3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                cr_reg[k] <= XW'(pa_reg[k]) - XW'(pb_reg[k]);
            end
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            box3_reg <= box2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            ex3_reg  <= ex2_reg;
            ey3_reg  <= ey2_reg;
        end
    end

    // stage 4: hit decision, magnitudes, signs, base and midpoint
    logic                 hit_next;
    logic                 par_next;
    logic [XW-1:0]        anum_next, aden_next;
    logic [DW-1:0]        aadx_next, aady_next;
    logic signed [W-1:0]  basex_next, basey_next, midx_next, midy_next;
    logic signed [CB:0]   sumx, sumy;
    logic signed [W-1:0]  vx, vy, tx, ty;

    always_comb
    begin
        hit_next = (opposite(cr_reg[0], cr_reg[1]) && opposite(cr_reg[2], cr_reg[3]))
                   || (cr_reg[0] == 0 && box3_reg[0])
                   || (cr_reg[1] == 0 && box3_reg[1])
                   || (cr_reg[2] == 0 && box3_reg[2])
                   || (cr_reg[3] == 0 && box3_reg[3]);
        par_next  = (cr_reg[4] == 0);
        anum_next = cr_reg[5][XW-1] ? $unsigned(-cr_reg[5]) : $unsigned(cr_reg[5]);
        aden_next = cr_reg[4][XW-1] ? $unsigned(-cr_reg[4]) : $unsigned(cr_reg[4]);
        aadx_next = adx3_reg[DW-1] ? $unsigned(-adx3_reg) : $unsigned(adx3_reg);
        aady_next = ady3_reg[DW-1] ? $unsigned(-ady3_reg) : $unsigned(ady3_reg);
        basex_next = W'(ax3_reg) <<< FB;
        basey_next = W'(ay3_reg) <<< FB;
        sumx = (CB+1)'(ax3_reg) + (CB+1)'(ex3_reg);
        sumy = (CB+1)'(ay3_reg) + (CB+1)'(ey3_reg);
        vx = W'(sumx) <<< FB;
        vy = W'(sumy) <<< FB;
        // halve, truncating toward zero
        tx = vx + $signed({{(W-1){1'b0}}, vx[W-1]});
        ty = vy + $signed({{(W-1){1'b0}}, vy[W-1]});
        midx_next = tx >>> 1;
        midy_next = ty >>> 1;
    end

    logic                v4_reg, hit4_reg, par4_reg, negx4_reg, negy4_reg;
    logic [XW-1:0]       anum4_reg, aden4_reg;
    logic [DW-1:0]       aadx4_reg, aady4_reg;
    logic signed [W-1:0] basex4_reg, basey4_reg, midx4_reg, midy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit4_reg   <= hit_next;
            par4_reg   <= par_next;
            negx4_reg  <= cr_reg[5][XW-1] ^ adx3_reg[DW-1] ^ cr_reg[4][XW-1];
            negy4_reg  <= cr_reg[5][XW-1] ^ ady3_reg[DW-1] ^ cr_reg[4][XW-1];
            anum4_reg  <= anum_next;
            aden4_reg  <= aden_next;
            aadx4_reg  <= aadx_next;
            aady4_reg  <= aady_next;
            basex4_reg <= basex_next;
            basey4_reg <= basey_next;
            midx4_reg  <= midx_next;
            midy4_reg  <= midy_next;
        end
    end

    // stage 5: dividend magnitudes
    logic [XW+DW-1:0] prodx, prody;
    logic             v5_reg;
    logic [NW-1:0]    numx5_reg, numy5_reg;
    logic [XW-1:0]    den5_reg;
    logic [SW-1:0]    side5_reg;

    assign prodx = anum4_reg * aadx4_reg;
    assign prody = anum4_reg * aady4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx5_reg <= NW'(prodx) << FB;
            numy5_reg <= NW'(prody) << FB;
            den5_reg  <= aden4_reg;
            side5_reg <= {hit4_reg, par4_reg, negx4_reg, negy4_reg,
                          basex4_reg, basey4_reg, midx4_reg, midy4_reg};
        end
    end

    assign valid = v5_reg;
    assign num_x = numx5_reg;
    assign num_y = numy5_reg;
    assign den   = den5_reg;
    assign side  = side5_reg;

endmodule

@@ rtl/spi_div_stage.sv @@
module spi_div_stage
    import spi_pkg::*;
#(
    parameter int RW  = 60,
    parameter int DVW = 35,
    parameter int QW  = 24,
    parameter int SW  = 132,
    parameter int BIT = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  logic [RW-1:0]  rem_x_in,
    input  logic [RW-1:0]  rem_y_in,
    input  logic [QW-1:0]  quo_x_in,
    input  logic [QW-1:0]  quo_y_in,
    input  logic [DVW-1:0] den_in,
    input  logic [SW-1:0]  side_in,
    output logic           valid_out,
    output logic [RW-1:0]  rem_x_out,
    output logic [RW-1:0]  rem_y_out,
    output logic [QW-1:0]  quo_x_out,
    output logic [QW-1:0]  quo_y_out,
    output logic [DVW-1:0] den_out,
    output logic [SW-1:0]  side_out
);

    logic [RW-1:0] trial;
    logic          ge_x, ge_y;
    logic [RW-1:0] rem_x_next, rem_y_next;
    logic [QW-1:0] quo_x_next, quo_y_next;

    // one restoring step for quotient bit BIT
    always_comb
    begin
        trial      = RW'(den_in) << BIT;
        ge_x       = (rem_x_in >= trial);
        ge_y       = (rem_y_in >= trial);
        rem_x_next = ge_x ? rem_x_in - trial : rem_x_in;
        rem_y_next = ge_y ? rem_y_in - trial : rem_y_in;
        quo_x_next = quo_x_in | (QW'(ge_x) << BIT);
        quo_y_next = quo_y_in | (QW'(ge_y) << BIT);
    end

    logic           valid_reg;
    logic [RW-1:0]  rem_x_reg, rem_y_reg;
    logic [QW-1:0]  quo_x_reg, quo_y_reg;
    logic [DVW-1:0] den_reg;
    logic [SW-1:0]  side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            den_reg   <= den_in;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign quo_x_out = quo_x_reg;
    assign quo_y_out = quo_y_reg;
    assign den_out   = den_reg;
    assign side_out  = side_reg;

endmodule

@@ rtl/segment_pair_intersection.sv @@
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   in_data  (spi_in_t, two segments)
// result    out        out_valid / out_ready out_data (spi_out_t, hit and point)
//
// One request enters per cycle while the output is not stalled; the path runs
// through five front stages for cross products and dividend
// magnitudes, one divider stage per quotient bit, one output register.
// The divider chain sets the depth: one restoring subtract per stage.
// Reset clears every valid bit; data registers are not reset.
// A result held at the output freezes the whole pipeline, so nothing is
// dropped or repeated; in_ready drops only while the output stalls.
module segment_pair_intersection
    import spi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  spi_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output spi_out_t out_data
);

    localparam int DW = COORD_BITS + 1;
    localparam int XW = 2 * DW + 1;
    localparam int NW = XW + DW + FRAC_BITS;
    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int W  = COORD_BITS + FRAC_BITS + 2;
    localparam int SW = 4 + 4 * W;
    localparam int EW = ((W > PT_W) ? W : PT_W) + 1;
    localparam logic signed [EW-1:0] SAT_HI = EW'((2 ** (PT_W - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = EW'(-(2 ** (PT_W - 1)));

    logic     out_valid_reg;
    spi_out_t out_data_reg;

    // advance everything unless a result is held at the output
    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic          vld_w  [QW+1];
    logic [NW-1:0] remx_w [QW+1];
    logic [NW-1:0] remy_w [QW+1];
    logic [QW-1:0] quox_w [QW+1];
    logic [QW-1:0] quoy_w [QW+1];
    logic [XW-1:0] den_w  [QW+1];
    logic [SW-1:0] side_w [QW+1];

    spi_front #(
        .CB (COORD_BITS),
        .FB (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .valid    (vld_w[0]),
        .num_x    (remx_w[0]),
        .num_y    (remy_w[0]),
        .den      (den_w[0]),
        .side     (side_w[0])
    );

    assign quox_w[0] = '0;
    assign quoy_w[0] = '0;

    // quotient bits, most significant first
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        spi_div_stage #(
            .RW  (NW),
            .DVW (XW),
            .QW  (QW),
            .SW  (SW),
            .BIT (QW - 1 - i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (vld_w[i]),
            .rem_x_in  (remx_w[i]),
            .rem_y_in  (remy_w[i]),
            .quo_x_in  (quox_w[i]),
            .quo_y_in  (quoy_w[i]),
            .den_in    (den_w[i]),
            .side_in   (side_w[i]),
            .valid_out (vld_w[i+1]),
            .rem_x_out (remx_w[i+1]),
            .rem_y_out (remy_w[i+1]),
            .quo_x_out (quox_w[i+1]),
            .quo_y_out (quoy_w[i+1]),
            .den_out   (den_w[i+1]),
            .side_out  (side_w[i+1])
        );
    end

    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > SAT_HI)
        begin
            e = SAT_HI;
        end
        else if (e < SAT_LO)
        begin
            e = SAT_LO;
        end
        return e[PT_W-1:0];
    endfunction

    // sideband fields from the end of the divider
    logic                f_hit, f_par, f_negx, f_negy;
    logic signed [W-1:0] f_basex, f_basey, f_midx, f_midy;
    logic signed [W-1:0] qx, qy, px, py;
    spi_out_t            out_next;

    always_comb
    begin
        f_hit   = side_w[QW][SW-1];
        f_par   = side_w[QW][SW-2];
        f_negx  = side_w[QW][SW-3];
        f_negy  = side_w[QW][SW-4];
        f_basex = $signed(side_w[QW][4*W-1:3*W]);
        f_basey = $signed(side_w[QW][3*W-1:2*W]);
        f_midx  = $signed(side_w[QW][2*W-1:W]);
        f_midy  = $signed(side_w[QW][W-1:0]);
        qx = $signed(W'(quox_w[QW]));
        qy = $signed(W'(quoy_w[QW]));
        if (f_negx)
        begin
            qx = -qx;
        end
        if (f_negy)
        begin
            qy = -qy;
        end
        // no hit: zero point; parallel hit: midpoint of A
        if (!f_hit)
        begin
            px = '0;
            py = '0;
        end
        else if (f_par)
        begin
            px = f_midx;
            py = f_midy;
        end
        else
        begin
            px = f_basex + qx;
            py = f_basey + qy;
        end
        out_next.hit      = f_hit;
        out_next.parallel = f_hit && f_par;
        out_next.point_x  = sat_pt(px);
        out_next.point_y  = sat_pt(py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_w[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/spi_checker.sv @@
module spi_checker
    import spi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input spi_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input spi_out_t out_data
);

    // hold a stalled request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a miss carries no point and no parallel flag
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |->
            !out_data.parallel && out_data.point_x == 0 && out_data.point_y == 0)
        else $error("miss with nonzero fields");

    a_par: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.parallel |-> out_data.hit)
        else $error("parallel without hit");

    // take no request while the output stalls
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken during stall");

endmodule

bind segment_pair_intersection spi_checker u_spi_checker (.*);
